// ===== design/lsx_pkg.sv =====
`default_nettype none
package lsx_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 32;
	localparam int unsigned CNT_W  = 6;

	// Header layout: the pixel-data offset sits in bytes 10 to 13.
	localparam logic [LEN_W-1:0] HDR_END   = 32'd14;
	localparam logic [LEN_W-1:0] HDR_LAST  = 32'd13;
	localparam logic [LEN_W-1:0] OFFSET_LO = 32'd10;
	localparam logic [BYTE_W-1:0] EXT_LIMIT = 8'd16;

	localparam logic [CNT_W-1:0] BITS_BYTE = 6'd8;
	localparam logic [CNT_W-1:0] BITS_LEN  = 6'd32;

	localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 32'd65536;
	localparam logic [BYTE_W-1:0] KEY_MAX_RST     = 8'd32;

	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_MAX     = 8'd1;

	typedef enum logic [2:0] {
		PH_HDR  = 3'd0,
		PH_KLEN = 3'd1,
		PH_KEY  = 3'd2,
		PH_ELEN = 3'd3,
		PH_EXT  = 3'd4,
		PH_PLEN = 3'd5,
		PH_PAY  = 3'd6,
		PH_IDLE = 3'd7
	} phase_t;

	localparam logic [2:0] SEC_KEY  = 3'd0;
	localparam logic [2:0] SEC_EXT  = 3'd1;
	localparam logic [2:0] SEC_PAY  = 3'd2;
	localparam logic [2:0] SEC_DONE = 3'd3;
	localparam logic [2:0] SEC_ERR  = 3'd4;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_KEY_LEN = 2'd1;
	localparam logic [1:0] ERR_EXT_LEN = 2'd2;
	localparam logic [1:0] ERR_PAY_LEN = 2'd3;

	typedef struct packed {
		logic [2:0]        section;
		logic [BYTE_W-1:0] data_byte;
		logic [LEN_W-1:0]  item_index;
		logic              last;
		logic [1:0]        error_code;
	} result_t;

endpackage
`default_nettype wire

// ===== design/lsx_parser.sv =====
`default_nettype none
module lsx_parser
	import lsx_pkg::*;
(
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    accept,
	input  wire [BYTE_W-1:0]       file_byte,
	input  wire                    start_req,
	input  wire [LEN_W-1:0]        max_payload_len,
	input  wire [BYTE_W-1:0]       key_max_len,
	output logic                   res_valid,
	output result_t                res
);

	phase_t            phase_q, phase_n;
	logic [LEN_W-1:0]  file_position_q, file_position_n;
	logic [LEN_W-1:0]  data_start_q, data_start_n;
	logic [CNT_W-1:0]  bit_count_q, bit_count_n;
	logic [LEN_W-1:0]  shift_accum_q, shift_accum_n;
	logic [LEN_W-1:0]  remaining_q, remaining_n;
	logic [LEN_W-1:0]  section_index_q, section_index_n;

	always_comb begin
		logic [LEN_W-1:0] pos;
		logic [LEN_W-1:0] val;
		logic [CNT_W-1:0] need;
		logic [1:0]       lane;
		logic             proceed;
		logic             data_word;
		logic [2:0]       data_sec;
		phase_t           data_next;

		phase_n         = phase_q;
		file_position_n = file_position_q;
		data_start_n    = data_start_q;
		bit_count_n     = bit_count_q;
		shift_accum_n   = shift_accum_q;
		remaining_n     = remaining_q;
		section_index_n = section_index_q;
		res_valid       = 1'b0;
		res             = '0;
		proceed         = 1'b0;
		data_word       = 1'b0;
		data_sec        = SEC_KEY;
		data_next       = PH_IDLE;
		val             = '0;
		need            = BITS_BYTE;

		if (start_req) begin
			phase_n         = PH_HDR;
			file_position_n = '0;
			data_start_n    = '0;
			bit_count_n     = '0;
			shift_accum_n   = '0;
			remaining_n     = '0;
			section_index_n = '0;
		end

		pos = file_position_n;
		if (file_position_n != {LEN_W{1'b1}}) begin
			file_position_n = file_position_n + 1'b1;
		end

		// Offset bytes 10..13 map to byte lanes 0..3 of the offset word.
		lane = pos[1:0] ^ 2'b10;

		if (phase_n == PH_HDR) begin
			if (pos < HDR_END) begin
				if (pos >= OFFSET_LO) begin
					data_start_n = data_start_n
						| ({{(LEN_W-BYTE_W){1'b0}}, file_byte} << {lane, 3'b000});
				end
				if (pos == HDR_LAST && data_start_n < HDR_END) begin
					data_start_n = HDR_END;
				end
			end else if (pos >= data_start_n) begin
				phase_n       = PH_KLEN;
				bit_count_n   = '0;
				shift_accum_n = '0;
				proceed       = 1'b1;
			end
		end else if (phase_n != PH_IDLE) begin
			proceed = 1'b1;
		end

		if (proceed) begin
			shift_accum_n = {shift_accum_n[LEN_W-2:0], file_byte[0]};
			bit_count_n   = bit_count_n + 1'b1;
			need          = (phase_n == PH_PLEN) ? BITS_LEN : BITS_BYTE;
			if (bit_count_n >= need) begin
				val           = shift_accum_n;
				bit_count_n   = '0;
				shift_accum_n = '0;
				unique case (phase_n)
					PH_KLEN: begin
						if (val[BYTE_W-1:0] == '0 || val[BYTE_W-1:0] > key_max_len) begin
							phase_n        = PH_IDLE;
							res_valid      = 1'b1;
							res.section    = SEC_ERR;
							res.last       = 1'b1;
							res.error_code = ERR_KEY_LEN;
						end else begin
							remaining_n     = {{(LEN_W-BYTE_W){1'b0}}, val[BYTE_W-1:0]};
							section_index_n = '0;
							phase_n         = PH_KEY;
						end
					end
					PH_KEY: begin
						data_word = 1'b1;
						data_sec  = SEC_KEY;
						data_next = PH_ELEN;
					end
					PH_ELEN: begin
						if (val[BYTE_W-1:0] >= EXT_LIMIT) begin
							phase_n        = PH_IDLE;
							res_valid      = 1'b1;
							res.section    = SEC_ERR;
							res.last       = 1'b1;
							res.error_code = ERR_EXT_LEN;
						end else begin
							remaining_n     = {{(LEN_W-BYTE_W){1'b0}}, val[BYTE_W-1:0]};
							section_index_n = '0;
							phase_n = (val[BYTE_W-1:0] == '0) ? PH_PLEN : PH_EXT;
						end
					end
					PH_EXT: begin
						data_word = 1'b1;
						data_sec  = SEC_EXT;
						data_next = PH_PLEN;
					end
					PH_PLEN: begin
						if (val > max_payload_len) begin
							phase_n        = PH_IDLE;
							res_valid      = 1'b1;
							res.section    = SEC_ERR;
							res.last       = 1'b1;
							res.error_code = ERR_PAY_LEN;
						end else if (val == '0) begin
							phase_n     = PH_IDLE;
							res_valid   = 1'b1;
							res.section = SEC_DONE;
							res.last    = 1'b1;
						end else begin
							remaining_n     = val;
							section_index_n = '0;
							phase_n         = PH_PAY;
						end
					end
					PH_PAY: begin
						data_word = 1'b1;
						data_sec  = SEC_PAY;
						data_next = PH_IDLE;
					end
					default: begin
						phase_n = PH_IDLE;
					end
				endcase

				if (data_word) begin
					res_valid       = 1'b1;
					res.section     = data_sec;
					res.data_byte   = val[BYTE_W-1:0];
					res.item_index  = section_index_n;
					res.last        = (remaining_n == {{(LEN_W-1){1'b0}}, 1'b1});
					res.error_code  = ERR_NONE;
					remaining_n     = remaining_n - 1'b1;
					section_index_n = section_index_n + 1'b1;
					if (res.last) begin
						phase_n         = data_next;
						section_index_n = '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HDR;
			file_position_q <= '0;
			data_start_q    <= '0;
			bit_count_q     <= '0;
			shift_accum_q   <= '0;
			remaining_q     <= '0;
			section_index_q <= '0;
		end else if (accept) begin
			phase_q         <= phase_n;
			file_position_q <= file_position_n;
			data_start_q    <= data_start_n;
			bit_count_q     <= bit_count_n;
			shift_accum_q   <= shift_accum_n;
			remaining_q     <= remaining_n;
			section_index_q <= section_index_n;
		end
	end

	// Any error or done result leaves the parser idle until the next start.
	a_err_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res_valid && (res.section == SEC_ERR || res.section == SEC_DONE)
		|=> phase_q == PH_IDLE)
		else $error("parser not idle after error or done word");

	// The final payload word closes the frame.
	a_pay_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res_valid && res.section == SEC_PAY && res.last
		|=> phase_q == PH_IDLE && section_index_q == '0)
		else $error("parser not idle after last payload word");

	// An idle parser stays silent unless a new file starts.
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE && !start_req |-> !res_valid)
		else $error("idle parser produced a word");

endmodule
`default_nettype wire

// ===== design/lsx_out_stage.sv =====
`default_nettype none
module lsx_out_stage
	import lsx_pkg::*;
(
	input  wire           clk,
	input  wire           arst_n,
	input  wire           load,
	input  wire result_t  res,
	output logic          room,
	output logic          out_valid,
	input  wire           out_ready,
	output result_t       out_res
);

	logic    valid_q;
	result_t res_q;

	// A held word that is taken this cycle frees the register for a new one.
	assign room      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> room)
		else $error("result register overwritten while stalled");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_q)
		else $error("loaded word not presented");

	a_drain_clears: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && out_ready && !load |=> !valid_q)
		else $error("taken word presented twice");

endmodule
`default_nettype wire

// ===== design/lsb_stego_extractor_core.sv =====
// LSB steganography extractor for BMP files.
// The slave stream takes one file byte per word: s_tdata[7:0] is the byte and
// s_tuser marks the first byte of a new file, which clears all parse state.
// The pixel-data offset is read from header bytes 10 to 13; from the offset on,
// the LSB of each byte is shifted in MSB first to rebuild the hidden frame.
// Every rebuilt key, extension or payload byte leaves on the master stream with
// its section in m_tuser and m_tlast on the final byte of its section. An empty
// payload gives one done word, a bad length gives one error word, and after
// either the block ignores bytes until the next start.
// The result of an accepted byte is registered before it is shown. One byte is
// accepted every cycle; a single result register sits between the parser and
// the master side, so s_tready drops only while that register holds a word
// that the receiver is not taking.
// After reset the limits are 65536 payload bytes and 32 key bytes, and the
// parser is set as for a fresh start. The configuration channel is always
// ready; index 0 writes the payload limit, index 1 the key limit, and other
// indexes are ignored. Write it only while no file is in flight.
`default_nettype none
module lsb_stego_extractor_core
	import lsx_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  wire  [7:0]           s_tdata,   // file_byte
	input  wire                  s_tuser,   // start_req
	output logic                 m_tvalid,
	input  wire                  m_tready,
	output logic [47:0]          m_tdata,   // data_byte, item_index, error_code, zero fill
	output logic [2:0]           m_tuser,   // section
	output logic                 m_tlast,   // last
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire  [CFG_IDX_W-1:0] cfg_index,
	input  wire  [31:0]          cfg_data
);

	logic [LEN_W-1:0]  max_payload_len_q;
	logic [BYTE_W-1:0] key_max_len_q;
	logic              accept;
	logic              room;
	logic              res_valid;
	result_t           res;
	result_t           out_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_len_q <= MAX_PAYLOAD_RST;
			key_max_len_q     <= KEY_MAX_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MAX_PAYLOAD: max_payload_len_q <= cfg_data;
				CFG_KEY_MAX:     key_max_len_q     <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_tready = room;
	assign accept   = s_tvalid && room;

	lsx_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.file_byte       (s_tdata),
		.start_req       (s_tuser),
		.max_payload_len (max_payload_len_q),
		.key_max_len     (key_max_len_q),
		.res_valid       (res_valid),
		.res             (res)
	);

	lsx_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && res_valid),
		.res       (res),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {6'b000000, out_res.error_code, out_res.item_index, out_res.data_byte};
	assign m_tuser = out_res.section;
	assign m_tlast = out_res.last;

endmodule
`default_nettype wire
